[rtl/core/tsa_pkg.sv]
package tsa_pkg;

    localparam int NUM_SOURCES_DEF = 8;
    localparam int NUM_METRICS_DEF = 8;
    localparam logic [31:0] STALE_RESET = 32'd3000;

    typedef enum logic [1:0] {
        OP_PUBLISH = 2'd0,
        OP_REMOVE  = 2'd1,
        OP_RESOLVE = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUB,
        S_REM,
        S_CLR,
        S_RD1,
        S_SCAN1,
        S_OWN_RD,
        S_OWN_CHK,
        S_RD2,
        S_SCAN2,
        S_DONE,
        S_OUT
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic write_sample;
        logic remove_src;
        logic clear_all;
        logic scan_reset;
        logic rd_issue;
        logic rd_own;
        logic scan1_step;
        logic own_check;
        logic scan2_step;
        logic finish;
        logic set_reject;
        logic load_out;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic op_pub_ok;
        logic src_ok;
        logic metric_ok;
        logic scan_last;
        logic any_fresh;
        logic own_ok;
        logic own_valid;
    } t_sts;

endpackage

[rtl/core/tsa_ram.sv]
module tsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/tsa_ctrl.sv]
module tsa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    output logic            o_valid,
    input  logic            i_stall,
    input  logic [1:0]      i_op,
    input  tsa_pkg::t_sts   i_sts,
    output tsa_pkg::t_cmd   o_cmd
);

    tsa_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            tsa_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    case (tsa_pkg::t_op'(i_op))
                        tsa_pkg::OP_PUBLISH: n_state = tsa_pkg::S_PUB;
                        tsa_pkg::OP_REMOVE:  n_state = tsa_pkg::S_REM;
                        tsa_pkg::OP_CLEAR:   n_state = tsa_pkg::S_CLR;
                        default:             n_state = tsa_pkg::S_RD1;
                    endcase
                end
            end
            tsa_pkg::S_PUB: begin
                o_cmd.write_sample = i_sts.op_pub_ok;
                o_cmd.set_reject   = 1'b1;
                n_state = tsa_pkg::S_OUT;
            end
            tsa_pkg::S_REM: begin
                o_cmd.remove_src = i_sts.src_ok;
                o_cmd.set_reject = 1'b1;
                n_state = tsa_pkg::S_OUT;
            end
            tsa_pkg::S_CLR: begin
                o_cmd.clear_all  = 1'b1;
                o_cmd.set_reject = 1'b1;
                n_state = tsa_pkg::S_OUT;
            end
            tsa_pkg::S_RD1: begin
                if (!i_sts.metric_ok) begin
                    o_cmd.set_reject = 1'b1;
                    n_state = tsa_pkg::S_OUT;
                end else begin
                    o_cmd.scan_reset = 1'b1;
                    o_cmd.rd_issue   = 1'b1;
                    n_state = tsa_pkg::S_SCAN1;
                end
            end
            tsa_pkg::S_SCAN1: begin
                o_cmd.scan1_step = 1'b1;
                o_cmd.rd_issue   = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = tsa_pkg::S_OWN_RD;
                end
            end
            tsa_pkg::S_OWN_RD: begin
                if (!i_sts.any_fresh) begin
                    o_cmd.finish = 1'b1;
                    n_state = tsa_pkg::S_DONE;
                end else begin
                    o_cmd.rd_own = 1'b1;
                    n_state = tsa_pkg::S_OWN_CHK;
                end
            end
            tsa_pkg::S_OWN_CHK: begin
                o_cmd.own_check = 1'b1;
                if (i_sts.own_ok && i_sts.own_valid) begin
                    n_state = tsa_pkg::S_DONE;
                end else begin
                    n_state = tsa_pkg::S_RD2;
                end
            end
            tsa_pkg::S_RD2: begin
                o_cmd.scan_reset = 1'b1;
                o_cmd.rd_issue   = 1'b1;
                n_state = tsa_pkg::S_SCAN2;
            end
            tsa_pkg::S_SCAN2: begin
                o_cmd.scan2_step = 1'b1;
                o_cmd.rd_issue   = 1'b1;
                if (i_sts.scan_last) begin
                    o_cmd.finish = 1'b1;
                    n_state = tsa_pkg::S_DONE;
                end
            end
            tsa_pkg::S_DONE: begin
                o_cmd.load_out = 1'b1;
                n_state = tsa_pkg::S_OUT;
            end
            tsa_pkg::S_OUT: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    n_state = tsa_pkg::S_IDLE;
                end
            end
            default: n_state = tsa_pkg::S_IDLE;
        endcase
    end

endmodule

[rtl/core/tsa_dp.sv]
module tsa_dp #(
    parameter int NUM_SOURCES = tsa_pkg::NUM_SOURCES_DEF,
    parameter int NUM_METRICS = tsa_pkg::NUM_METRICS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tsa_pkg::t_cmd   i_cmd,
    output tsa_pkg::t_sts   o_sts,
    input  logic [1:0]      i_op,
    input  logic [3:0]      i_source_slot,
    input  logic [3:0]      i_metric,
    input  logic [63:0]     i_value_bits,
    input  logic            i_priority_req,
    input  logic [31:0]     i_now_ms,
    input  logic [31:0]     i_stale,
    output logic            o_ok,
    output logic [63:0]     o_result_value,
    output logic [3:0]      o_owner_slot,
    output logic            o_owner_priority
);

    localparam int SW    = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int MW    = (NUM_METRICS > 1) ? $clog2(NUM_METRICS) : 1;
    localparam int DEPTH = NUM_SOURCES * (1 << MW);
    localparam int AW    = $clog2(DEPTH) > 0 ? $clog2(DEPTH) : 1;
    localparam int DW    = 64 + 1 + 32;

    logic [1:0]  r_op;
    logic [3:0]  r_src;
    logic [3:0]  r_metric;
    logic [63:0] r_val;
    logic        r_prio;
    logic [31:0] r_now;

    logic [NUM_SOURCES-1:0] r_valid [NUM_METRICS];
    logic [3:0] r_owner [NUM_METRICS];

    logic [3:0]  r_rd_slot;   // slot index (0-based) of issued read
    logic [3:0]  r_ev_slot;   // slot index of data now on ram output
    logic        r_ev_en;
    logic        r_any;
    logic        r_best;
    logic [3:0]  r_sel;
    logic [31:0] r_sel_time;
    logic [63:0] r_sel_val;
    logic        r_sel_prio;

    logic        r_ok;
    logic [63:0] r_out_val;
    logic [3:0]  r_out_slot;
    logic        r_out_prio;

    logic          src_ok, metric_ok, finite;
    logic [SW-1:0] src_idx;
    logic [MW-1:0] m_idx;
    logic [AW-1:0] waddr, raddr;
    logic [DW-1:0] wdata, rdata;
    logic [3:0]    rd_slot;
    logic [63:0]   rd_val;
    logic          rd_prio;
    logic [31:0]   rd_time;
    logic          rd_valid, rd_fresh;
    logic [3:0]    own;
    logic          own_in;

    assign src_ok    = (r_src != 4'd0) && ({1'b0, r_src} <= 5'(NUM_SOURCES));
    assign metric_ok = {1'b0, r_metric} < 5'(NUM_METRICS);
    assign finite    = r_val[62:52] != 11'h7ff;
    assign src_idx   = SW'(r_src - 4'd1);
    assign m_idx     = r_metric[MW-1:0];
    assign own       = r_owner[m_idx];
    assign own_in    = (own != 4'd0) && ({1'b0, own} <= 5'(NUM_SOURCES));

    assign waddr = AW'({src_idx, m_idx});
    assign wdata = {r_val, r_prio, r_now};
    assign rd_slot = i_cmd.rd_own ? 4'(own - 4'd1) : r_rd_slot;
    assign raddr = AW'({rd_slot[SW-1:0], m_idx});

    tsa_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write_sample),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rd_val   = rdata[DW-1 -: 64];
    assign rd_prio  = rdata[32];
    assign rd_time  = rdata[31:0];
    assign rd_valid = r_valid[m_idx][r_ev_slot[SW-1:0]];
    assign rd_fresh = rd_valid && ((r_now < rd_time) || ((r_now - rd_time) <= i_stale));

    assign o_sts.op_pub_ok = src_ok && metric_ok && finite;
    assign o_sts.src_ok    = src_ok;
    assign o_sts.metric_ok = metric_ok;
    assign o_sts.scan_last = r_ev_en && ({1'b0, r_ev_slot} == 5'(NUM_SOURCES - 1));
    assign o_sts.any_fresh = r_any;
    assign o_sts.own_ok    = rd_fresh && (rd_prio == r_best);
    assign o_sts.own_valid = own_in;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_op;
            r_src    <= i_source_slot;
            r_metric <= i_metric;
            r_val    <= i_value_bits;
            r_prio   <= i_priority_req;
            r_now    <= i_now_ms;
        end
        if (i_cmd.scan_reset) begin
            r_rd_slot <= 4'd0;
            r_ev_en   <= 1'b0;
        end else if (i_cmd.rd_issue) begin
            r_rd_slot <= r_rd_slot + 4'd1;
            r_ev_en   <= 1'b1;
            r_ev_slot <= r_rd_slot;
        end
        if (i_cmd.rd_own) begin
            r_ev_slot <= 4'(own - 4'd1);
        end
        if (i_cmd.capture) begin
            r_any  <= 1'b0;
            r_best <= 1'b0;
            r_sel  <= 4'd0;
        end else if (i_cmd.scan1_step && r_ev_en && rd_fresh) begin
            if (!r_any || rd_prio) begin
                r_best <= rd_prio;
            end
            r_any <= 1'b1;
        end
        if (i_cmd.own_check) begin
            if (own_in && o_sts.own_ok) begin
                r_sel      <= own;
                r_sel_val  <= rd_val;
                r_sel_prio <= rd_prio;
            end else begin
                r_sel <= 4'd0;
            end
        end else if (i_cmd.scan2_step && r_ev_en && rd_fresh && rd_prio == r_best) begin
            if (r_sel == 4'd0 || rd_time > r_sel_time) begin
                r_sel      <= r_ev_slot + 4'd1;
                r_sel_time <= rd_time;
                r_sel_val  <= rd_val;
                r_sel_prio <= rd_prio;
            end
        end
        if (i_cmd.set_reject) begin
            r_ok       <= (r_op == tsa_pkg::OP_PUBLISH) && o_sts.op_pub_ok;
            r_out_val  <= 64'd0;
            r_out_slot <= 4'd0;
            r_out_prio <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_ok       <= r_sel != 4'd0;
            r_out_val  <= (r_sel != 4'd0) ? r_sel_val : 64'd0;
            r_out_slot <= r_sel;
            r_out_prio <= (r_sel != 4'd0) ? r_sel_prio : 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < NUM_METRICS; m++) begin
                r_valid[m] <= '0;
                r_owner[m] <= 4'd0;
            end
        end else begin
            if (i_cmd.write_sample) begin
                r_valid[m_idx][src_idx] <= 1'b1;
            end
            if (i_cmd.remove_src) begin
                for (int m = 0; m < NUM_METRICS; m++) begin
                    r_valid[m][src_idx] <= 1'b0;
                    if (r_owner[m] == r_src) begin
                        r_owner[m] <= 4'd0;
                    end
                end
            end
            if (i_cmd.clear_all) begin
                for (int m = 0; m < NUM_METRICS; m++) begin
                    r_valid[m] <= '0;
                    r_owner[m] <= 4'd0;
                end
            end
            // owner updated when scan ends or no fresh sample
            if (i_cmd.finish) begin
                if (!r_any) begin
                    r_owner[m_idx] <= 4'd0;
                end else if (r_ev_en && rd_fresh && rd_prio == r_best
                        && (r_sel == 4'd0 || rd_time > r_sel_time)) begin
                    r_owner[m_idx] <= r_ev_slot + 4'd1;
                end else begin
                    r_owner[m_idx] <= r_sel;
                end
            end
        end
    end

    assign o_ok             = r_ok;
    assign o_result_value   = r_out_val;
    assign o_owner_slot     = r_out_slot;
    assign o_owner_priority = r_out_prio;

endmodule

[rtl/core/telemetry_source_arbiter.sv]
// channel | direction | handshake      | payload
// input   | in        | valid / stall  | op, source_slot, metric, value_bits, priority_req, now_ms
// output  | out       | valid / stall  | ok, result_value, owner_slot, owner_priority
// config  | in        | valid / ready  | stale_after_ms
// publish, remove and clear each pass through a single working state before the result is
// offered; resolve, for a valid metric, makes one or two scans over the source slots
// through the one read port of the sample memory
// reset clears valid bits, owners and the freshness limit (3000) at once, no clearing pass
// a new request is taken only once the previous result has been delivered
module telemetry_source_arbiter #(
    parameter int NUM_SOURCES = tsa_pkg::NUM_SOURCES_DEF,
    parameter int NUM_METRICS = tsa_pkg::NUM_METRICS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic [3:0]  i_source_slot,
    input  logic [3:0]  i_metric,
    input  logic [63:0] i_value_bits,
    input  logic        i_priority_req,
    input  logic [31:0] i_now_ms,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_ok,
    output logic [63:0] o_result_value,
    output logic [3:0]  o_owner_slot,
    output logic        o_owner_priority,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_stale_after_ms
);

    tsa_pkg::t_cmd cmd;
    tsa_pkg::t_sts sts;
    logic [31:0]   r_stale;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stale <= tsa_pkg::STALE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_stale <= i_cfg_stale_after_ms;
        end
    end

    tsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_op    (i_op),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    tsa_dp #(.NUM_SOURCES(NUM_SOURCES), .NUM_METRICS(NUM_METRICS)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_op             (i_op),
        .i_source_slot    (i_source_slot),
        .i_metric         (i_metric),
        .i_value_bits     (i_value_bits),
        .i_priority_req   (i_priority_req),
        .i_now_ms         (i_now_ms),
        .i_stale          (r_stale),
        .o_ok             (o_ok),
        .o_result_value   (o_result_value),
        .o_owner_slot     (o_owner_slot),
        .o_owner_priority (o_owner_priority)
    );

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("request accepted while result pending");
    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_result_value == 64'd0 && o_owner_slot == 4'd0))
        else $error("nonzero payload on failed request");
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, o_owner_slot} <= 5'(NUM_SOURCES)))
        else $error("owner slot out of range");
`endif

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;

    localparam int NSRC = 8;
    localparam int NMET = 8;

    typedef struct packed {
        logic        ok;
        logic [63:0] value;
        logic [3:0]  slot;
        logic        prio;
    } t_answer;

    typedef struct {
        tsa_pkg::t_op op;
        logic [3:0]  src;
        logic [3:0]  metric;
        logic [63:0] value;
        logic        prio;
        logic [31:0] now;
        logic        has_exp;
        t_answer     exp;
    } t_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_op = '0;
    logic [3:0]  i_source_slot = '0;
    logic [3:0]  i_metric = '0;
    logic [63:0] i_value_bits = '0;
    logic        i_priority_req = 1'b0;
    logic [31:0] i_now_ms = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_ok;
    logic [63:0] o_result_value;
    logic [3:0]  o_owner_slot;
    logic        o_owner_priority;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_stale_after_ms = '0;

    telemetry_source_arbiter u_top (.*);

    always #10 i_clk = ~i_clk;

    // shadow copy of the sample store
    logic        shadow_valid [NSRC+1][NMET];
    logic [63:0] shadow_value [NSRC+1][NMET];
    logic        shadow_prio  [NSRC+1][NMET];
    logic [31:0] shadow_time  [NSRC+1][NMET];
    logic [3:0]  shadow_owner [NMET];
    logic [31:0] stale_limit;

    t_answer pending_answers[$];
    int      err_count = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;

    function automatic logic sample_fresh(int s, int m, logic [31:0] now);
        if (!shadow_valid[s][m]) return 1'b0;
        if (now < shadow_time[s][m]) return 1'b1;
        return (now - shadow_time[s][m]) <= stale_limit;
    endfunction

    function automatic t_answer arbitrate(t_req r);
        t_answer a;
        logic any;
        logic best;
        int sel;
        int own;
        int m;
        a = '0;
        m = r.metric;
        case (r.op)
            tsa_pkg::OP_PUBLISH: begin
                if (r.src == 0 || r.src > NSRC || r.metric >= NMET) return a;
                if (r.value[62:52] == 11'h7ff) return a;
                shadow_valid[r.src][m] = 1'b1;
                shadow_value[r.src][m] = r.value;
                shadow_prio[r.src][m] = r.prio;
                shadow_time[r.src][m] = r.now;
                a.ok = 1'b1;
            end
            tsa_pkg::OP_REMOVE: begin
                if (r.src == 0 || r.src > NSRC) return a;
                for (int k = 0; k < NMET; k++) begin
                    shadow_valid[r.src][k] = 1'b0;
                    if (shadow_owner[k] == r.src) shadow_owner[k] = '0;
                end
            end
            tsa_pkg::OP_CLEAR: begin
                for (int s = 1; s <= NSRC; s++)
                    for (int k = 0; k < NMET; k++) shadow_valid[s][k] = 1'b0;
                for (int k = 0; k < NMET; k++) shadow_owner[k] = '0;
            end
            default: begin
                if (r.metric >= NMET) return a;
                any = 1'b0;
                best = 1'b0;
                for (int s = 1; s <= NSRC; s++) begin
                    if (!sample_fresh(s, m, r.now)) continue;
                    if (!any || shadow_prio[s][m] > best) best = shadow_prio[s][m];
                    any = 1'b1;
                end
                if (!any) begin
                    shadow_owner[m] = '0;
                    return a;
                end
                sel = 0;
                own = shadow_owner[m];
                if (own >= 1 && own <= NSRC)
                    if (sample_fresh(own, m, r.now) && shadow_prio[own][m] == best) sel = own;
                if (sel == 0) begin
                    for (int s = 1; s <= NSRC; s++) begin
                        if (!sample_fresh(s, m, r.now) || shadow_prio[s][m] != best) continue;
                        if (sel == 0 || shadow_time[s][m] > shadow_time[sel][m]) sel = s;
                    end
                    shadow_owner[m] = sel[3:0];
                end
                if (sel == 0) return a;
                a.ok = 1'b1;
                a.value = shadow_value[sel][m];
                a.slot = sel[3:0];
                a.prio = shadow_prio[sel][m];
            end
        endcase
        return a;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_answer w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected result", {63'd0, o_ok}, '0);
            end else begin
                w = pending_answers.pop_front();
                if (o_ok !== w.ok) report_mismatch("ok", 64'(o_ok), 64'(w.ok));
                if (o_result_value !== w.value) report_mismatch("value", o_result_value, w.value);
                if (o_owner_slot !== w.slot)
                    report_mismatch("slot", 64'(o_owner_slot), 64'(w.slot));
                if (o_owner_priority !== w.prio)
                    report_mismatch("priority", 64'(o_owner_priority), 64'(w.prio));
            end
        end
    end

    // receiver stall
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_request(t_req r);
        t_answer a;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        a = arbitrate(r);
        if (r.has_exp && a !== r.exp) begin
            report_mismatch("table row ok", 64'(a.ok), 64'(r.exp.ok));
            report_mismatch("table row value", a.value, r.exp.value);
            report_mismatch("table row slot", 64'(a.slot), 64'(r.exp.slot));
            report_mismatch("table row priority", 64'(a.prio), 64'(r.exp.prio));
        end
        pending_answers.push_back(a);
        i_valid <= 1'b1;
        i_op <= r.op;
        i_source_slot <= r.src;
        i_metric <= r.metric;
        i_value_bits <= r.value;
        i_priority_req <= r.prio;
        i_now_ms <= r.now;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_answers.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_stale(logic [31:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_stale_after_ms <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        stale_limit = v;
    endtask

    function automatic t_req make_req(tsa_pkg::t_op op, int src, int m, logic [63:0] v,
                                      logic p, logic [31:0] now);
        t_req r;
        r.op = op;
        r.src = src[3:0];
        r.metric = m[3:0];
        r.value = v;
        r.prio = p;
        r.now = now;
        r.has_exp = 1'b0;
        r.exp = '0;
        return r;
    endfunction

    function automatic t_req rand_req(logic [31:0] base);
        t_req r;
        int k;
        logic [63:0] v;
        k = $urandom_range(99);
        v = {$urandom, $urandom};
        if ($urandom_range(9) == 0) v[62:52] = 11'h7ff;
        r = make_req(tsa_pkg::OP_PUBLISH, $urandom_range(1, NSRC), $urandom_range(NMET - 1), v,
                     1'($urandom_range(1)), base + $urandom_range(4000));
        if (k < 45) begin
            r.op = tsa_pkg::OP_PUBLISH;
        end else if (k < 85) begin
            r.op = tsa_pkg::OP_RESOLVE;
        end else if (k < 92) begin
            r.op = tsa_pkg::OP_REMOVE;
        end else if (k < 94) begin
            r.op = tsa_pkg::OP_CLEAR;
        end else begin
            r.op = tsa_pkg::t_op'($urandom_range(3));
            r.src = 4'($urandom_range(15));
            r.metric = 4'($urandom_range(15));
            r.now = $urandom;
        end
        return r;
    endfunction

    t_req dir_table[$];

    initial begin
        t_req r;
        logic [31:0] stale_set [4];
        logic [31:0] base;
        for (int s = 0; s <= NSRC; s++)
            for (int k = 0; k < NMET; k++) begin
                shadow_valid[s][k] = 1'b0;
                shadow_value[s][k] = '0;
                shadow_prio[s][k] = 1'b0;
                shadow_time[s][k] = '0;
            end
        for (int k = 0; k < NMET; k++) shadow_owner[k] = '0;
        stale_limit = tsa_pkg::STALE_RESET;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        r = make_req(tsa_pkg::OP_RESOLVE, 0, 0, '0, 0, 0);
        r.has_exp = 1'b1;
        dir_table.push_back(r);
        r = make_req(tsa_pkg::OP_PUBLISH, 0, 0, 64'h3ff0_0000_0000_0000, 0, 5);
        r.has_exp = 1'b1;
        dir_table.push_back(r);
        r = make_req(tsa_pkg::OP_PUBLISH, 9, 0, 64'h3ff0_0000_0000_0000, 0, 5);
        r.has_exp = 1'b1;
        dir_table.push_back(r);
        r = make_req(tsa_pkg::OP_PUBLISH, 15, 15, '1, 1, '1);
        r.has_exp = 1'b1;
        dir_table.push_back(r);
        r = make_req(tsa_pkg::OP_PUBLISH, 1, 8, 64'h0, 0, 5);
        r.has_exp = 1'b1;
        dir_table.push_back(r);
        r = make_req(tsa_pkg::OP_PUBLISH, 1, 0, 64'h7ff0_0000_0000_0000, 0, 5);
        r.has_exp = 1'b1;
        dir_table.push_back(r);
        r = make_req(tsa_pkg::OP_PUBLISH, 1, 0, 64'hfff8_0000_0000_0001, 1, 5);
        r.has_exp = 1'b1;
        dir_table.push_back(r);
        r = make_req(tsa_pkg::OP_RESOLVE, 0, 15, '0, 1, '1);
        r.has_exp = 1'b1;
        dir_table.push_back(r);
        dir_table.push_back(make_req(tsa_pkg::OP_PUBLISH, 1, 0, 64'h0, 0, 100));
        dir_table.push_back(make_req(tsa_pkg::OP_PUBLISH, 8, 0, 64'hffef_ffff_ffff_ffff, 0,
                                     100));
        dir_table.push_back(make_req(tsa_pkg::OP_RESOLVE, 0, 0, '0, 0, 100));
        dir_table.push_back(make_req(tsa_pkg::OP_PUBLISH, 3, 0, 64'h7fef_ffff_ffff_ffff, 1,
                                     50));
        dir_table.push_back(make_req(tsa_pkg::OP_RESOLVE, 0, 0, '0, 0, 3050));
        dir_table.push_back(make_req(tsa_pkg::OP_RESOLVE, 0, 0, '0, 0, 3051));
        dir_table.push_back(make_req(tsa_pkg::OP_PUBLISH, 5, 7, 64'h1, 1, 32'hffff_ffff));
        dir_table.push_back(make_req(tsa_pkg::OP_RESOLVE, 0, 7, '0, 0, 0));
        dir_table.push_back(make_req(tsa_pkg::OP_REMOVE, 0, 0, '0, 0, 0));
        dir_table.push_back(make_req(tsa_pkg::OP_REMOVE, 12, 0, '0, 0, 0));
        dir_table.push_back(make_req(tsa_pkg::OP_REMOVE, 5, 0, '0, 0, 0));
        dir_table.push_back(make_req(tsa_pkg::OP_RESOLVE, 0, 7, '0, 0, 0));
        dir_table.push_back(make_req(tsa_pkg::OP_RESOLVE, 0, 0, '0, 0, 200));
        dir_table.push_back(make_req(tsa_pkg::OP_CLEAR, 0, 0, '0, 0, 0));
        dir_table.push_back(make_req(tsa_pkg::OP_RESOLVE, 0, 0, '0, 0, 200));
        foreach (dir_table[i]) send_request(dir_table[i]);
        drain();

        stale_set[0] = 32'd0;
        stale_set[1] = 32'hffff_ffff;
        stale_set[2] = 32'd1500;
        stale_set[3] = 32'd3000;
        for (int ph = 0; ph < 5; ph++) begin
            write_stale(stale_set[ph % 4]);
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                3: begin send_idle_pct = 25; recv_stall_pct = 25; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            base = (ph == 4) ? 32'hffff_f000 : $urandom_range(100000);
            for (int n = 0; n < 150; n++) send_request(rand_req(base));
            drain();
        end

        recv_stall_pct = 0;
        drain();
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
rtl/core/tsa_pkg.sv
rtl/core/tsa_ram.sv
rtl/core/tsa_ctrl.sv
rtl/core/tsa_dp.sv
rtl/core/telemetry_source_arbiter.sv
tb/tb.sv
